// ===== hdl/apt_pkg.sv =====
package apt_pkg;

   localparam int COORD_WIDTH_DEFAULT = 32;
   localparam int FRAC_BITS_DEFAULT   = 16;

   localparam int FIELD_WIDTH = 32;
   localparam int AXES        = 3;
   localparam int CSR_COUNT   = 6;
   localparam int CSR_WIDTH   = 64;
   localparam int CSR_IDX_W   = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POSE_ROW0_A = 3'd0,
      CSR_POSE_ROW0_B = 3'd1,
      CSR_POSE_ROW1_A = 3'd2,
      CSR_POSE_ROW1_B = 3'd3,
      CSR_POSE_ROW2_A = 3'd4,
      CSR_POSE_ROW2_B = 3'd5
   } apt_csr_type;

   localparam logic [CSR_WIDTH-1:0] POSE_ROW0_A_RESET = 64'h0001_0000_0000_0000;
   localparam logic [CSR_WIDTH-1:0] POSE_ROW0_B_RESET = 64'h0000_0000_0000_0000;
   localparam logic [CSR_WIDTH-1:0] POSE_ROW1_A_RESET = 64'h0000_0000_0001_0000;
   localparam logic [CSR_WIDTH-1:0] POSE_ROW1_B_RESET = 64'h0000_0000_0000_0000;
   localparam logic [CSR_WIDTH-1:0] POSE_ROW2_A_RESET = 64'h0000_0000_0000_0000;
   localparam logic [CSR_WIDTH-1:0] POSE_ROW2_B_RESET = 64'h0001_0000_0000_0000;

   // load enables of the four pipeline stages
   typedef struct packed {
      logic s1_en;
      logic s2_en;
      logic s3_en;
      logic s4_en;
   } apt_stage_ctl_type;

endpackage

// ===== hdl/aabb_pose_transform_unit.sv =====
// channel | direction | tdata (low bit up)                   | tuser      | handshake
// req     | in        | min_x min_y min_z max_x max_y max_z  | box_valid  | tvalid/tready
// rsp     | out       | min_x min_y min_z max_x max_y max_z  | out_valid  | tvalid/tready
// csr     | in        | csr_wdata: 64-bit register value     | -          | csr_we, csr_index
//
// Four-stage pipeline, one box per cycle while the output is not stalled.
// Stages: corner products, per-term min/max, term sums, floor/translate/saturate.
// Each stage holds while the one after it is full and stalled; bubbles collapse.
// Synchronous reset empties the pipeline and loads the identity pose.
module aabb_pose_transform_unit #(
   parameter int COORD_WIDTH = apt_pkg::COORD_WIDTH_DEFAULT,
   parameter int FRAC_BITS   = apt_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [6*apt_pkg::FIELD_WIDTH-1:0] req_tdata,  // min_x,min_y,min_z,max_x,max_y,max_z
   input  logic                              req_tuser,  // box_valid
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [6*apt_pkg::FIELD_WIDTH-1:0] rsp_tdata,  // min_x,min_y,min_z,max_x,max_y,max_z
   output logic                              rsp_tuser,  // out_valid
   input  logic                              csr_we,
   input  logic [apt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [apt_pkg::CSR_WIDTH-1:0]     csr_wdata
);
   import apt_pkg::*;

   localparam int STAGES = 4;
   localparam int DW     = 6 * FIELD_WIDTH;

   logic [CSR_WIDTH-1:0] pose_ff [CSR_COUNT];
   logic [STAGES-1:0]    vld_ff, vld_in, rdy;
   logic                 flag_ff [STAGES];
   logic [DW-1:0]        raw_ff [STAGES];
   apt_stage_ctl_type    ctl;

   logic signed [FIELD_WIDTH-1:0] coef [AXES][AXES];
   logic signed [FIELD_WIDTH-1:0] trans [AXES];
   logic signed [COORD_WIDTH-1:0] lo [AXES];
   logic signed [COORD_WIDTH-1:0] hi [AXES];
   logic signed [FIELD_WIDTH-1:0] res_min [AXES];
   logic signed [FIELD_WIDTH-1:0] res_max [AXES];

   // pose registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pose_ff[CSR_POSE_ROW0_A] <= POSE_ROW0_A_RESET;
         pose_ff[CSR_POSE_ROW0_B] <= POSE_ROW0_B_RESET;
         pose_ff[CSR_POSE_ROW1_A] <= POSE_ROW1_A_RESET;
         pose_ff[CSR_POSE_ROW1_B] <= POSE_ROW1_B_RESET;
         pose_ff[CSR_POSE_ROW2_A] <= POSE_ROW2_A_RESET;
         pose_ff[CSR_POSE_ROW2_B] <= POSE_ROW2_B_RESET;
      end else if (csr_we) begin
         unique case (apt_csr_type'(csr_index))
            CSR_POSE_ROW0_A: pose_ff[CSR_POSE_ROW0_A] <= csr_wdata;
            CSR_POSE_ROW0_B: pose_ff[CSR_POSE_ROW0_B] <= csr_wdata;
            CSR_POSE_ROW1_A: pose_ff[CSR_POSE_ROW1_A] <= csr_wdata;
            CSR_POSE_ROW1_B: pose_ff[CSR_POSE_ROW1_B] <= csr_wdata;
            CSR_POSE_ROW2_A: pose_ff[CSR_POSE_ROW2_A] <= csr_wdata;
            CSR_POSE_ROW2_B: pose_ff[CSR_POSE_ROW2_B] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         coef[i][0] = pose_ff[2*i][2*FIELD_WIDTH-1:FIELD_WIDTH];
         coef[i][1] = pose_ff[2*i][FIELD_WIDTH-1:0];
         coef[i][2] = pose_ff[2*i+1][2*FIELD_WIDTH-1:FIELD_WIDTH];
         trans[i]   = pose_ff[2*i+1][FIELD_WIDTH-1:0];
         lo[i]      = req_tdata[i*FIELD_WIDTH +: COORD_WIDTH];
         hi[i]      = req_tdata[(i+AXES)*FIELD_WIDTH +: COORD_WIDTH];
      end
   end

   // stage handshake
   always_comb begin
      rdy[STAGES-1] = !vld_ff[STAGES-1] || rsp_tready;
      for (int s = STAGES - 2; s >= 0; s--) begin
         rdy[s] = !vld_ff[s] || rdy[s+1];
      end
      vld_in[0] = rdy[0] ? req_tvalid : vld_ff[0];
      for (int s = 1; s < STAGES; s++) begin
         vld_in[s] = rdy[s] ? vld_ff[s-1] : vld_ff[s];
      end
      ctl.s1_en = rdy[0];
      ctl.s2_en = rdy[1];
      ctl.s3_en = rdy[2];
      ctl.s4_en = rdy[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // flag and untouched box travel beside the arithmetic
   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         flag_ff[0] <= req_tuser;
         raw_ff[0]  <= req_tdata;
      end
      for (int s = 1; s < STAGES; s++) begin
         if (rdy[s]) begin
            flag_ff[s] <= flag_ff[s-1];
            raw_ff[s]  <= raw_ff[s-1];
         end
      end
   end

   for (genvar i = 0; i < AXES; i++) begin : g_row
      apt_row #(
         .COORD_WIDTH(COORD_WIDTH),
         .FRAC_BITS  (FRAC_BITS)
      ) u_row (
         .clock  (clock),
         .ctl    (ctl),
         .coef   (coef[i]),
         .trans  (trans[i]),
         .lo     (lo),
         .hi     (hi),
         .res_min(res_min[i]),
         .res_max(res_max[i])
      );
   end

   assign req_tready = rdy[0];
   assign rsp_tvalid = vld_ff[STAGES-1];
   assign rsp_tuser  = flag_ff[STAGES-1];
   assign rsp_tdata  = flag_ff[STAGES-1] ?
                       {res_max[2], res_max[1], res_max[0],
                        res_min[2], res_min[1], res_min[0]} :
                       raw_ff[STAGES-1];

   a_bounds_ordered: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |->
         ($signed(rsp_tdata[31:0])  <= $signed(rsp_tdata[127:96])) &&
         ($signed(rsp_tdata[63:32]) <= $signed(rsp_tdata[159:128])) &&
         ($signed(rsp_tdata[95:64]) <= $signed(rsp_tdata[191:160])))
      else $error("computed min above max");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      ((&vld_ff) && !rsp_tready) |-> !req_tready)
      else $error("accepting into a full stalled pipeline");

   a_bubble_fill: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[STAGES-2] && !vld_ff[STAGES-1]) |=> vld_ff[STAGES-1])
      else $error("word lost in a bubble");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(flag_ff[STAGES-1])))
      else $error("output stage dropped a stalled word");

endmodule

// ===== hdl/apt_row.sv =====
module apt_row #(
   parameter int COORD_WIDTH = apt_pkg::COORD_WIDTH_DEFAULT,
   parameter int FRAC_BITS   = apt_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  apt_pkg::apt_stage_ctl_type             ctl,
   input  logic signed [apt_pkg::FIELD_WIDTH-1:0] coef [apt_pkg::AXES],
   input  logic signed [apt_pkg::FIELD_WIDTH-1:0] trans,
   input  logic signed [COORD_WIDTH-1:0]          lo [apt_pkg::AXES],
   input  logic signed [COORD_WIDTH-1:0]          hi [apt_pkg::AXES],
   output logic signed [apt_pkg::FIELD_WIDTH-1:0] res_min,
   output logic signed [apt_pkg::FIELD_WIDTH-1:0] res_max
);
   import apt_pkg::*;

   localparam int PW = FIELD_WIDTH + COORD_WIDTH;
   localparam int SW = PW + 2;
   localparam int AW = SW + 1;
   localparam logic signed [AW-1:0] SAT_HI =
      AW'((65'sd1 <<< (COORD_WIDTH - 1)) - 65'sd1);
   localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);

   logic signed [PW-1:0] prod_lo_ff [AXES];
   logic signed [PW-1:0] prod_hi_ff [AXES];
   logic signed [PW-1:0] term_min_ff [AXES];
   logic signed [PW-1:0] term_max_ff [AXES];
   logic signed [SW-1:0] sum_min_ff, sum_max_ff, sum_min_in, sum_max_in;
   logic signed [AW-1:0] val_min, val_max;
   logic signed [COORD_WIDTH-1:0] sat_min, sat_max;
   logic signed [FIELD_WIDTH-1:0] res_min_ff, res_max_ff;

   // stage 1: both products per term
   always_ff @(posedge clock) begin
      if (ctl.s1_en) begin
         for (int k = 0; k < AXES; k++) begin
            prod_lo_ff[k] <= PW'(coef[k]) * PW'(lo[k]);
            prod_hi_ff[k] <= PW'(coef[k]) * PW'(hi[k]);
         end
      end
   end

   // stage 2: extreme of each term over its two corner choices
   always_ff @(posedge clock) begin
      if (ctl.s2_en) begin
         for (int k = 0; k < AXES; k++) begin
            if (prod_lo_ff[k] < prod_hi_ff[k]) begin
               term_min_ff[k] <= prod_lo_ff[k];
               term_max_ff[k] <= prod_hi_ff[k];
            end else begin
               term_min_ff[k] <= prod_hi_ff[k];
               term_max_ff[k] <= prod_lo_ff[k];
            end
         end
      end
   end

   // stage 3: sum of terms
   always_comb begin
      sum_min_in = SW'(term_min_ff[0]) + SW'(term_min_ff[1]) + SW'(term_min_ff[2]);
      sum_max_in = SW'(term_max_ff[0]) + SW'(term_max_ff[1]) + SW'(term_max_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (ctl.s3_en) begin
         sum_min_ff <= sum_min_in;
         sum_max_ff <= sum_max_in;
      end
   end

   // stage 4: floor, translate, saturate
   always_comb begin
      val_min = AW'(sum_min_ff >>> FRAC_BITS) + AW'(trans);
      val_max = AW'(sum_max_ff >>> FRAC_BITS) + AW'(trans);
      if (val_min > SAT_HI) begin
         sat_min = COORD_WIDTH'(SAT_HI);
      end else if (val_min < SAT_LO) begin
         sat_min = COORD_WIDTH'(SAT_LO);
      end else begin
         sat_min = COORD_WIDTH'(val_min);
      end
      if (val_max > SAT_HI) begin
         sat_max = COORD_WIDTH'(SAT_HI);
      end else if (val_max < SAT_LO) begin
         sat_max = COORD_WIDTH'(SAT_LO);
      end else begin
         sat_max = COORD_WIDTH'(val_max);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.s4_en) begin
         res_min_ff <= FIELD_WIDTH'(sat_min);
         res_max_ff <= FIELD_WIDTH'(sat_max);
      end
   end

   assign res_min = res_min_ff;
   assign res_max = res_max_ff;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
   import apt_pkg::*;

   localparam int FW = FIELD_WIDTH;
   localparam logic signed [95:0] SAT_HI = (96'sd1 <<< (COORD_WIDTH_DEFAULT - 1)) - 96'sd1;
   localparam logic signed [95:0] SAT_LO = -SAT_HI - 96'sd1;
   localparam logic [31:0] Q_ONE   = 32'h0001_0000;
   localparam logic [31:0] Q_MAX   = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN   = 32'h8000_0000;
   localparam logic [31:0] Q_HALFN = 32'hFFFF_8000;
   localparam logic [31:0] Q_QTR   = 32'h0000_4000;
   localparam logic [31:0] Q_LSBN  = 32'hFFFF_FFFF;
   localparam int RANDOM_PHASES = 9;
   localparam int BOXES_PER_PHASE = 100;

   // coord[0] = min_x ... coord[5] = max_z, matches tdata packing
   typedef struct packed {
      logic                valid;
      logic [5:0][FW-1:0]  coord;
   } box_word_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [6*FW-1:0]      req_tdata = '0;
   logic                 req_tuser = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [6*FW-1:0]      rsp_tdata;
   logic                 rsp_tuser;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_WIDTH-1:0] csr_wdata = '0;

   logic [CSR_WIDTH-1:0] pose_reg [CSR_COUNT] = '{POSE_ROW0_A_RESET, POSE_ROW0_B_RESET,
                                                  POSE_ROW1_A_RESET, POSE_ROW1_B_RESET,
                                                  POSE_ROW2_A_RESET, POSE_ROW2_B_RESET};
   box_word_type pending_boxes [$];
   box_word_type expected_boxes [$];
   int        send_idle_pct = 22;
   int        recv_idle_pct = 76;
   int        errors = 0;
   string     coord_name [6] = '{"min_x", "min_y", "min_z", "max_x", "max_y", "max_z"};

   aabb_pose_transform_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [FW-1:0] map_axis(int row, logic signed [FW-1:0] px,
                                              logic signed [FW-1:0] py,
                                              logic signed [FW-1:0] pz);
      logic signed [FW-1:0] c0, c1, c2, t;
      logic signed [95:0]   acc;
      c0  = pose_reg[2*row][63:32];
      c1  = pose_reg[2*row][31:0];
      c2  = pose_reg[2*row+1][63:32];
      t   = pose_reg[2*row+1][31:0];
      acc = c0 * px + c1 * py + c2 * pz;
      acc = (acc >>> FRAC_BITS_DEFAULT) + t;
      if (acc > SAT_HI) acc = SAT_HI;
      if (acc < SAT_LO) acc = SAT_LO;
      return acc[FW-1:0];
   endfunction

   function automatic box_word_type transform_box(box_word_type b);
      box_word_type         r;
      logic signed [FW-1:0] v, lo_v, hi_v;
      logic signed [FW-1:0] p [3];
      r = b;
      if (!b.valid) return r;
      for (int row = 0; row < AXES; row++) begin
         lo_v = '0;
         hi_v = '0;
         for (int c = 0; c < 8; c++) begin
            for (int a = 0; a < AXES; a++)
               p[a] = c[a] ? b.coord[3+a] : b.coord[a];
            v = map_axis(row, p[0], p[1], p[2]);
            if (c == 0 || v < lo_v) lo_v = v;
            if (c == 0 || v > hi_v) hi_v = v;
         end
         r.coord[row]   = lo_v;
         r.coord[3+row] = hi_v;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [FW-1:0] got, logic [FW-1:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      box_word_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid)
            expected_boxes.insert(expected_boxes.size(),
                                  transform_box({req_tuser, req_tdata}));
         if (pending_boxes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = pending_boxes.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= nxt.valid;
            req_tdata  <= nxt.coord;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      box_word_type want;
      box_word_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata};
            if (expected_boxes.size() == 0) begin
               report_mismatch("unexpected word", got.coord[0], '0);
            end else begin
               want = expected_boxes.pop_front();
               if (got.valid !== want.valid)
                  report_mismatch("out_valid", 32'(got.valid), 32'(want.valid));
               for (int k = 0; k < 6; k++)
                  if (got.coord[k] !== want.coord[k])
                     report_mismatch(coord_name[k], got.coord[k], want.coord[k]);
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic add_box(logic valid, logic [FW-1:0] mnx, logic [FW-1:0] mny,
                          logic [FW-1:0] mnz, logic [FW-1:0] mxx, logic [FW-1:0] mxy,
                          logic [FW-1:0] mxz);
      box_word_type b;
      b.valid = valid;
      b.coord = {mxz, mxy, mxx, mnz, mny, mnx};
      pending_boxes.insert(pending_boxes.size(), b);
   endtask

   task automatic csr_write(apt_csr_type idx, logic [CSR_WIDTH-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      pose_reg[idx] = value;
   endtask

   task automatic write_pose(logic [CSR_WIDTH-1:0] r0a, logic [CSR_WIDTH-1:0] r0b,
                             logic [CSR_WIDTH-1:0] r1a, logic [CSR_WIDTH-1:0] r1b,
                             logic [CSR_WIDTH-1:0] r2a, logic [CSR_WIDTH-1:0] r2b);
      csr_write(CSR_POSE_ROW0_A, r0a);
      csr_write(CSR_POSE_ROW0_B, r0b);
      csr_write(CSR_POSE_ROW1_A, r1a);
      csr_write(CSR_POSE_ROW1_B, r1b);
      csr_write(CSR_POSE_ROW2_A, r2a);
      csr_write(CSR_POSE_ROW2_B, r2b);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // sender holds off until the pipeline is empty
   task automatic drain;
      while (pending_boxes.size() > 0 || req_tvalid || expected_boxes.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [FW-1:0] rand_q();
      case ($urandom_range(7))
         0: return '0;
         1: return $urandom_range(1) ? Q_ONE : -Q_ONE;
         2: return $urandom_range(1) ? Q_MAX : Q_MIN;
         3, 4, 5: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [FW-1:0] rand_coord();
      case ($urandom_range(5))
         0: return $urandom_range(1) ? Q_MAX : Q_MIN;
         1, 2: return $urandom_range(32'h001F_FFFF) - 32'h0010_0000;
         default: return $urandom();
      endcase
   endfunction

   task automatic add_random_box;
      logic [FW-1:0] c [6];
      logic [FW-1:0] tmp;
      for (int k = 0; k < 6; k++) c[k] = rand_coord();
      if ($urandom_range(1)) begin
         for (int a = 0; a < AXES; a++)
            if ($signed(c[a]) > $signed(c[3+a])) begin
               tmp = c[a];
               c[a] = c[3+a];
               c[3+a] = tmp;
            end
      end
      add_box($urandom_range(9) != 0, c[0], c[1], c[2], c[3], c[4], c[5]);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // identity pose from reset
      add_box(1'b1, '0, '0, '0, '0, '0, '0);
      add_box(1'b1, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
      add_box(1'b1, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
      add_box(1'b1, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
      add_box(1'b0, '0, '0, '0, '0, '0, '0);
      add_box(1'b0, Q_LSBN, Q_MIN, Q_MAX, 32'h1234_5678, 32'hDEAD_BEEF, 32'h0F0F_F0F0);
      add_box(1'b1, 32'h0040_0000, 32'h0001_0000, 32'h7000_0000, -32'h0040_0000,
              -32'h0001_0000, Q_MIN);
      add_box(1'b1, Q_LSBN, Q_LSBN, Q_LSBN, 32'd1, 32'd1, 32'd1);
      drain();

      write_pose({Q_MAX, Q_MAX}, {Q_MAX, Q_MAX}, {Q_MAX, Q_MAX},
                 {Q_MAX, Q_MAX}, {Q_MAX, Q_MAX}, {Q_MAX, Q_MAX});
      add_box(1'b1, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
      add_box(1'b1, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
      add_box(1'b1, Q_LSBN, Q_LSBN, Q_LSBN, 32'd1, 32'd1, 32'd1);
      drain();

      write_pose({Q_MIN, Q_MIN}, {Q_MIN, Q_MIN}, {Q_MIN, Q_MIN},
                 {Q_MIN, Q_MIN}, {Q_MIN, Q_MIN}, {Q_MIN, Q_MIN});
      add_box(1'b1, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
      add_box(1'b1, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
      add_box(1'b0, Q_MIN, Q_MAX, Q_LSBN, '0, Q_ONE, Q_MIN);
      drain();

      // fractional coefficients exercise floor on odd coordinates
      write_pose({Q_HALFN, Q_QTR}, {Q_QTR, Q_LSBN}, {Q_QTR, Q_HALFN},
                 {Q_QTR, Q_LSBN}, {Q_QTR, Q_QTR}, {Q_HALFN, Q_LSBN});
      add_box(1'b1, 32'd1, 32'd3, 32'd5, 32'd7, 32'd9, 32'd11);
      add_box(1'b1, -32'd3, -32'd1, -32'd7, 32'd1, Q_LSBN, 32'd3);
      add_box(1'b1, Q_MIN, 32'd1, Q_MAX, Q_MAX, Q_LSBN, Q_MIN);
      drain();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph < 3) begin
            send_idle_pct = 22;
            recv_idle_pct = 76;
         end else if (ph < 6) begin
            send_idle_pct = 76;
            recv_idle_pct = 22;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_pose({rand_q(), rand_q()}, {rand_q(), rand_q()}, {rand_q(), rand_q()},
                    {rand_q(), rand_q()}, {rand_q(), rand_q()}, {rand_q(), rand_q()});
         repeat (BOXES_PER_PHASE) add_random_box();
         drain();
      end

      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
